// ----- src/srfs_pkg.sv -----
// Package for the sensor response frame synchronizer.
// Holds the input operation and result status codes and the frame constants.
// No dependencies.
package srfs_pkg;

    typedef enum logic [0:0] {
        OP_BYTE  = 1'b0,
        OP_START = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_CSUM_ERR = 2'd1,
        STATUS_RANGE    = 2'd2
    } status_t;

    localparam logic [7:0]  HDR_START       = 8'hFF;
    localparam logic [7:0]  HDR_CMD         = 8'h86;
    localparam logic [3:0]  FRAME_LAST      = 4'd8;
    localparam logic [15:0] RANGE_LIMIT_RST = 16'd5000;

endpackage

// ----- src/srfs_if.sv -----
// Valid/ready channel interfaces for the frame synchronizer.
// Depends on srfs_pkg for the operation and status types.
interface srfs_in_if
    import srfs_pkg::*;
();
    logic       valid;
    logic       ready;
    op_t        operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface srfs_out_if
    import srfs_pkg::*;
();
    logic        valid;
    logic        ready;
    status_t     status;
    logic [15:0] co2_ppm;

    modport source (output valid, output status, output co2_ppm, input ready);
    modport sink   (input valid, input status, input co2_ppm, output ready);
endinterface

// ----- src/sensor_response_frame_sync.sv -----
// Usage:
//   item   : input beats, operation OP_START opens a request and clears
//            alignment, OP_BYTE carries one received byte in rx_byte.
//   result : one beat per completed nine-byte frame: status (ok, checksum
//            error, out of range) and co2_ppm (zero on checksum error).
//   cfg_we / cfg_wdata : write of the range limit, taken on any edge with
//            cfg_we high; write only while no beat is in flight.
// Path: a byte is registered at the input, processed from there by the step,
//   and its result is registered in the result register once the closing
//   checksum byte has been processed.
// Throughput: one input beat per cycle while the stage does not stall; the single
//   step between the input register and the result register sets that figure.
// Reset: no request open, alignment cleared, limit back to 5000 ppm, both
//   registers empty.
// Stall: while a result waits, bytes that do not close a frame still flow;
//   the stage stops only when a new result would overwrite an untaken one,
//   and item.ready then drops once the input register is full.
// Depends on srfs_pkg and srfs_if.
module sensor_response_frame_sync
    import srfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    srfs_in_if.sink           item,
    srfs_out_if.source        result,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata
);

    logic        in_vld_reg;
    op_t         in_op_reg;
    logic [7:0]  in_byte_reg;

    logic        open_reg, open_next;
    logic [3:0]  fill_count_reg, fill_count_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  high_reg, high_next;
    logic [7:0]  low_reg, low_next;
    logic [15:0] limit_reg;

    logic        res_vld_reg;
    status_t     res_status_reg, res_status_next;
    logic [15:0] res_ppm_reg, res_ppm_next;

    logic        emit;
    logic        advance;
    logic        step;
    logic [15:0] reading;
    logic [7:0]  sum_all;

    // stage blocks only when a new result would overwrite an untaken one
    assign advance    = !res_vld_reg || result.ready || !emit;
    assign step       = in_vld_reg && advance;
    assign item.ready = !in_vld_reg || advance;

    assign reading = {high_reg, low_reg};
    assign sum_all = sum_reg + in_byte_reg;

    always_comb
    begin
        open_next       = open_reg;
        fill_count_next = fill_count_reg;
        sum_next        = sum_reg;
        high_next       = high_reg;
        low_next        = low_reg;
        emit            = 1'b0;
        res_status_next = STATUS_OK;
        res_ppm_next    = reading;
        if (in_op_reg == OP_START)
        begin
            open_next       = 1'b1;
            fill_count_next = '0;
            sum_next        = '0;
        end
        else if (open_reg)
        begin
            case (fill_count_reg)
                4'd1:
                begin
                    if (in_byte_reg == HDR_CMD)
                    begin
                        sum_next        = in_byte_reg;
                        fill_count_next = 4'd2;
                    end
                    else
                    begin
                        sum_next        = '0;
                        fill_count_next = (in_byte_reg == HDR_START) ? 4'd1 : 4'd0;
                    end
                end
                4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7:
                begin
                    if (fill_count_reg == 4'd2)
                    begin
                        high_next = in_byte_reg;
                    end
                    if (fill_count_reg == 4'd3)
                    begin
                        low_next = in_byte_reg;
                    end
                    sum_next        = sum_all;
                    fill_count_next = fill_count_reg + 4'd1;
                end
                FRAME_LAST:
                begin
                    // negated sum matches when sum plus checksum wraps to zero
                    emit = 1'b1;
                    if (sum_all != 8'd0)
                    begin
                        res_status_next = STATUS_CSUM_ERR;
                        res_ppm_next    = '0;
                    end
                    else if (reading > limit_reg)
                    begin
                        res_status_next = STATUS_RANGE;
                    end
                    open_next       = 1'b0;
                    fill_count_next = '0;
                    sum_next        = '0;
                end
                default:
                begin
                    // header search; counts above the frame length land here too
                    if (in_byte_reg == HDR_START)
                    begin
                        fill_count_next = 4'd1;
                        sum_next        = '0;
                    end
                    else
                    begin
                        fill_count_next = 4'd0;
                    end
                end
            endcase
        end
        emit = emit && in_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            open_reg       <= 1'b0;
            fill_count_reg <= '0;
            sum_reg        <= '0;
            high_reg       <= '0;
            low_reg        <= '0;
            limit_reg      <= RANGE_LIMIT_RST;
            res_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (item.ready)
            begin
                in_vld_reg <= item.valid;
            end
            if (step)
            begin
                open_reg       <= open_next;
                fill_count_reg <= fill_count_next;
                sum_reg        <= sum_next;
                high_reg       <= high_next;
                low_reg        <= low_next;
            end
            if (step && emit)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_op_reg   <= item.operation;
            in_byte_reg <= item.rx_byte;
        end
        if (step && emit)
        begin
            res_status_reg <= res_status_next;
            res_ppm_reg    <= res_ppm_next;
        end
    end

    assign result.valid   = res_vld_reg;
    assign result.status  = res_status_reg;
    assign result.co2_ppm = res_ppm_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FRAME_LAST)
        else $error("fill count beyond frame length");

    a_closed_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> fill_count_reg == 4'd0)
        else $error("alignment held with no request open");

    a_close_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step && emit) |=> (!open_reg && fill_count_reg == 4'd0 && res_vld_reg))
        else $error("request not closed after result");

    a_csum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == STATUS_CSUM_ERR) |-> result.co2_ppm == 16'd0)
        else $error("checksum error result carries a reading");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !res_vld_reg |-> item.ready)
        else $error("input stalled with empty result register");
`endif

endmodule

// ----- sim/sensor_response_frame_sync_tb.sv -----
`timescale 1ns / 100ps
// Testbench for sensor_response_frame_sync: a directed frame table, then random
// request sequences over several range limits, checked against a frame predictor.
// Depends on srfs_pkg, srfs_if and the sensor_response_frame_sync RTL.
module sensor_response_frame_sync_tb;
    import srfs_pkg::*;

    typedef struct packed {
        status_t     status;
        logic [15:0] ppm;
    } frame_res_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       typed;
        frame_res_t res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    srfs_in_if  in_ch ();
    srfs_out_if out_ch ();

    sensor_response_frame_sync DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_ch),
        .result    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    bit          sync_open;
    logic [3:0]  sync_fill;
    logic [7:0]  sync_sum;
    logic [7:0]  sync_hi;
    logic [7:0]  sync_lo;
    logic [15:0] limit_ppm;

    frame_res_t  pending_frames[$];
    dir_row_t    dir_tab[$];
    int unsigned beats_counted;
    int unsigned mismatches;
    bit          no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic bit frame_step(input op_t op, input logic [7:0] b,
                                      output frame_res_t res);
        logic [7:0]  csum_exp;
        logic [15:0] reading;
        res = '0;
        if (op == OP_START)
        begin
            sync_open = 1'b1;
            sync_fill = 4'd0;
            sync_sum  = 8'd0;
            return 1'b0;
        end
        if (!sync_open)
            return 1'b0;
        if (sync_fill > FRAME_LAST)
            sync_fill = 4'd0;
        if (sync_fill == 4'd0)
        begin
            if (b == HDR_START)
            begin
                sync_fill = 4'd1;
                sync_sum  = 8'd0;
            end
            return 1'b0;
        end
        if (sync_fill == 4'd1)
        begin
            if (b != HDR_CMD)
            begin
                sync_fill = (b == HDR_START) ? 4'd1 : 4'd0;
                sync_sum  = 8'd0;
            end
            else
            begin
                sync_sum  = b;
                sync_fill = 4'd2;
            end
            return 1'b0;
        end
        if (sync_fill < FRAME_LAST)
        begin
            if (sync_fill == 4'd2)
                sync_hi = b;
            else if (sync_fill == 4'd3)
                sync_lo = b;
            sync_sum  = sync_sum + b;
            sync_fill = sync_fill + 4'd1;
            return 1'b0;
        end
        csum_exp = 8'd0 - sync_sum;
        reading  = {sync_hi, sync_lo};
        if (csum_exp != b)
            res = '{STATUS_CSUM_ERR, 16'd0};
        else if (reading > limit_ppm)
            res = '{STATUS_RANGE, reading};
        else
            res = '{STATUS_OK, reading};
        sync_open = 1'b0;
        sync_fill = 4'd0;
        sync_sum  = 8'd0;
        return 1'b1;
    endfunction

    task automatic add_row(input op_t op, input logic [7:0] b, input bit typed = 1'b0,
                           input status_t st = STATUS_OK, input logic [15:0] ppm = 16'd0);
        dir_row_t r;
        r.op    = op;
        r.data  = b;
        r.typed = typed;
        r.res   = '{st, ppm};
        dir_tab.push_back(r);
    endtask

    // called at a falling edge; returns at a falling edge
    task automatic send_beat(input op_t op, input logic [7:0] b, input bit typed = 1'b0,
                             input frame_res_t typed_res = '0);
        frame_res_t  res;
        bit          got;
        int unsigned gap;
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.rx_byte   <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (op == OP_START || sync_open)
            beats_counted++;
        got = frame_step(op, b, res);
        if (typed)
            pending_frames.push_back(typed_res);
        else if (got)
            pending_frames.push_back(res);
        @(negedge clk);
        gap = no_gaps ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_limit(input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        limit_ppm = v;
    endtask

    task automatic gen_seq();
        int unsigned kind;
        int unsigned n;
        logic [15:0] rd;
        logic [7:0]  b;
        logic [7:0]  csum;
        no_gaps = ($urandom_range(0, 3) == 0);
        kind = $urandom_range(0, 99);
        if (kind < 72)
        begin
            send_beat(OP_START, 8'($urandom));
            n = $urandom_range(0, 3);
            repeat (n) send_beat(OP_BYTE, 8'($urandom_range(0, 254)));
            n = $urandom_range(0, 2);
            repeat (n) send_beat(OP_BYTE, HDR_START);
            send_beat(OP_BYTE, HDR_START);
            send_beat(OP_BYTE, HDR_CMD);
            case ($urandom_range(0, 9))
                0, 1:    rd = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                2, 3, 4: rd = limit_ppm + 16'($urandom_range(0, 2)) - 16'd1;
                default: rd = 16'($urandom);
            endcase
            csum = HDR_CMD + rd[15:8] + rd[7:0];
            send_beat(OP_BYTE, rd[15:8]);
            send_beat(OP_BYTE, rd[7:0]);
            repeat (4)
            begin
                b = 8'($urandom);
                csum = csum + b;
                send_beat(OP_BYTE, b);
            end
            csum = 8'd0 - csum;
            if ($urandom_range(0, 6) == 0)
                csum = csum ^ 8'($urandom_range(1, 255));
            send_beat(OP_BYTE, csum);
        end
        else if (kind < 82)
        begin
            // broken header
            send_beat(OP_START, 8'($urandom));
            send_beat(OP_BYTE, HDR_START);
            b = 8'($urandom);
            if (b == HDR_CMD)
                b = 8'h00;
            send_beat(OP_BYTE, b);
        end
        else if (kind < 90)
        begin
            // partial frame, left for the next sequence to restart or corrupt
            send_beat(OP_START, 8'($urandom));
            send_beat(OP_BYTE, HDR_START);
            send_beat(OP_BYTE, HDR_CMD);
            n = $urandom_range(0, 6);
            repeat (n) send_beat(OP_BYTE, 8'($urandom));
        end
        else
        begin
            n = $urandom_range(1, 8);
            repeat (n)
                send_beat(($urandom_range(0, 9) == 0) ? OP_START : OP_BYTE, 8'($urandom));
        end
    endtask

    initial
    begin
        int unsigned run;
        int unsigned stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            out_ch.ready <= 1'b1;
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
            repeat (run) @(negedge clk);
            stall = pick_gap();
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        frame_res_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: status %0d ppm %0d",
                             out_ch.status, out_ch.co2_ppm);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (out_ch.status != want.status || out_ch.co2_ppm != want.ppm)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status exp %0d got %0d, ppm exp %0d got %0d",
                                 want.status, out_ch.status, want.ppm, out_ch.co2_ppm);
                end
            end
        end
    end

    initial
    begin
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_BYTE;
        in_ch.rx_byte   = 8'd0;
        cfg_we          = 1'b0;
        cfg_wdata       = 16'd0;
        rst_n           = 1'b0;
        sync_open       = 1'b0;
        sync_fill       = 4'd0;
        sync_sum        = 8'd0;
        sync_hi         = 8'd0;
        sync_lo         = 8'd0;
        limit_ppm       = RANGE_LIMIT_RST;
        beats_counted   = 0;
        mismatches      = 0;
        no_gaps         = 1'b0;

        add_row(OP_BYTE, 8'hFF);                     // no request open
        add_row(OP_START, 8'h00);
        add_row(OP_BYTE, 8'h00);                     // dropped before header
        add_row(OP_BYTE, HDR_START);
        add_row(OP_BYTE, HDR_START);                 // header stays pending
        add_row(OP_BYTE, HDR_CMD);
        repeat (6) add_row(OP_BYTE, 8'hFF);
        add_row(OP_BYTE, 8'h80, 1'b1, STATUS_RANGE, 16'hFFFF);
        add_row(OP_START, 8'hFF);
        add_row(OP_BYTE, HDR_START);
        add_row(OP_BYTE, 8'h12);                     // broken header
        add_row(OP_BYTE, HDR_START);
        add_row(OP_BYTE, HDR_CMD);
        add_row(OP_START, 8'h5A);                    // restart mid-frame
        add_row(OP_BYTE, HDR_START);
        add_row(OP_BYTE, HDR_CMD);
        add_row(OP_BYTE, 8'h13);
        add_row(OP_BYTE, 8'h88);
        repeat (4) add_row(OP_BYTE, 8'h00);
        add_row(OP_BYTE, 8'h00, 1'b1, STATUS_CSUM_ERR, 16'd0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
            send_beat(dir_tab[i].op, dir_tab[i].data, dir_tab[i].typed, dir_tab[i].res);
        wait_idle();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       set_limit(16'd0);
                1:       set_limit(16'hFFFF);
                3:       set_limit(RANGE_LIMIT_RST);
                4:       set_limit(16'd1);
                default: set_limit(16'($urandom));
            endcase
            while (beats_counted < dir_tab.size() + (phase + 1) * 150)
                gen_seq();
            wait_idle();
        end

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
src/srfs_pkg.sv
src/srfs_if.sv
src/sensor_response_frame_sync.sv
sim/sensor_response_frame_sync_tb.sv
